[design/imu_tg_pkg.sv]
// Shared constants, types and the arctangent table for the IMU tilt and gyro unit.
package imu_tg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int SCALE_SHIFT  = 31 - SAMPLE_BITS;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam int SQ_W    = 63;
   localparam int ROOT_W  = 32;
   localparam int CW      = 36;
   localparam int ZW      = 25;
   localparam int ACC_W   = 48;
   localparam int PROD_W  = 33;
   localparam int TURN_W  = 34;
   localparam int TURN_LSB = 14;

   localparam logic signed [15:0] TILT_LIMIT   = 16'sd23040;
   localparam logic [15:0]        PERIOD_RESET = 16'd655;

   typedef struct packed {
      logic               done;
      logic               zero;
      logic signed [15:0] angle;
   } lane_res_type;

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_SQ   = 4'b0010,
      L_ROOT = 4'b0100,
      L_ROT  = 4'b1000
   } lane_state_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_BUSY = 3'b010,
      S_HOLD = 3'b100
   } top_state_type;

   // atan(2^-k) in 2^-16 degree, rounded.
   function automatic logic [21:0] atan_deg16(input logic [4:0] k);
      logic [21:0] r;
      case (k)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

[design/imu_tg_isqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
module imu_tg_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [imu_tg_pkg::SQ_W-1:0]     value,
   output logic                            done,
   output logic [imu_tg_pkg::ROOT_W-1:0]   root
);

   logic [imu_tg_pkg::SQ_W-1:0] rem_ff, rem_in;
   logic [imu_tg_pkg::SQ_W-1:0] res_ff, res_in;
   logic [imu_tg_pkg::SQ_W-1:0] bit_ff, bit_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [imu_tg_pkg::SQ_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = value;
         res_in  = '0;
         bit_in  = {1'b1, {(imu_tg_pkg::SQ_W-1){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[imu_tg_pkg::ROOT_W-1:0];

endmodule

[design/imu_tg_cordic.sv]
// Vectoring CORDIC, one rotation per cycle, with rounding and clamping of the angle.
module imu_tg_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [imu_tg_pkg::CW-1:0]  x_start,
   input  logic signed [imu_tg_pkg::CW-1:0]  y_start,
   output logic                              done,
   output logic signed [15:0]                angle
);

   logic signed [imu_tg_pkg::CW-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [imu_tg_pkg::ZW-1:0]  z_ff, z_in, atn, rnd, shifted;
   logic [imu_tg_pkg::STEP_W-1:0]     k_ff, k_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   assign dx  = y_ff >>> k_ff;
   assign dy  = x_ff >>> k_ff;
   assign atn = imu_tg_pkg::ZW'(imu_tg_pkg::atan_deg16(5'(k_ff)));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x_start;
         y_in    = y_start;
         z_in    = '0;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff < 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atn;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atn;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == imu_tg_pkg::STEP_W'(imu_tg_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      k_ff <= k_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Round to 1/256 degree, then clamp to +-90 degrees.
   assign rnd     = z_ff + imu_tg_pkg::ZW'(128);
   assign shifted = rnd >>> 8;

   always_comb begin
      if (shifted > imu_tg_pkg::ZW'(imu_tg_pkg::TILT_LIMIT)) begin
         angle = imu_tg_pkg::TILT_LIMIT;
      end else if (shifted < -imu_tg_pkg::ZW'(imu_tg_pkg::TILT_LIMIT)) begin
         angle = -imu_tg_pkg::TILT_LIMIT;
      end else begin
         angle = shifted[15:0];
      end
   end

   assign done = done_ff;

endmodule

[design/imu_tg_lane.sv]
// One tilt lane: magnitude by square root, then the arctangent by CORDIC.
module imu_tg_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [15:0]        a,
   input  logic signed [15:0]        b,
   input  logic signed [15:0]        num,
   input  logic                      z_mode,
   output imu_tg_pkg::lane_res_type  res
);

   imu_tg_pkg::lane_state_type state_ff, state_in;
   logic signed [15:0] a_ff, b_ff, num_ff;
   logic               zmode_ff;
   logic signed [31:0] a_sq, b_sq;
   logic [31:0]        sq_sum;
   logic [imu_tg_pkg::SQ_W-1:0]   sqrt_value;
   logic [imu_tg_pkg::ROOT_W-1:0] root;
   logic               sqrt_start, sqrt_done, rot_start, rot_done;
   logic signed [16:0] num_ext, num_abs;
   logic signed [imu_tg_pkg::CW-1:0] x_start, y_start;
   logic signed [15:0] angle;

   assign a_sq       = a_ff * a_ff;
   assign b_sq       = b_ff * b_ff;
   assign sq_sum     = $unsigned(a_sq) + $unsigned(b_sq);
   assign sqrt_value = imu_tg_pkg::SQ_W'(sq_sum) << (2 * imu_tg_pkg::SCALE_SHIFT);

   assign num_ext = 17'(num_ff);
   assign num_abs = (num_ff < 0) ? -num_ext : num_ext;

   // The z lane puts |az| on the x axis and the horizontal magnitude on y.
   always_comb begin
      if (zmode_ff) begin
         x_start = imu_tg_pkg::CW'(num_abs) <<< imu_tg_pkg::SCALE_SHIFT;
         y_start = imu_tg_pkg::CW'(root);
      end else begin
         x_start = imu_tg_pkg::CW'(root);
         y_start = imu_tg_pkg::CW'(num_ff) <<< imu_tg_pkg::SCALE_SHIFT;
      end
   end

   assign sqrt_start = (state_ff == imu_tg_pkg::L_SQ);
   assign rot_start  = (state_ff == imu_tg_pkg::L_ROOT) && sqrt_done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imu_tg_pkg::L_IDLE: if (start) state_in = imu_tg_pkg::L_SQ;
         imu_tg_pkg::L_SQ:   state_in = imu_tg_pkg::L_ROOT;
         imu_tg_pkg::L_ROOT: if (sqrt_done) state_in = imu_tg_pkg::L_ROT;
         imu_tg_pkg::L_ROT:  if (rot_done) state_in = imu_tg_pkg::L_IDLE;
         default:            state_in = imu_tg_pkg::L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff     <= a;
         b_ff     <= b;
         num_ff   <= num;
         zmode_ff <= z_mode;
      end
      if (reset) begin
         state_ff <= imu_tg_pkg::L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   imu_tg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (root)
   );

   imu_tg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (rot_start),
      .x_start (x_start),
      .y_start (y_start),
      .done    (rot_done),
      .angle   (angle)
   );

   assign res.done  = rot_done;
   assign res.zero  = (root == '0);
   assign res.angle = angle;

endmodule

[design/imu_tilt_and_gyro_integrate_unit.sv]
// Top level: three tilt lanes, result merge, gyro integrators and the period register.
//
//  port group  dir  role
//  req_*       in   six samples, one word per item
//  rsp_*       out  three tilt angles and three integrated angles
//  csr_*       in   sample period register write
//
// A word passes from accept to result valid through 32 square-root steps and
// CORDIC_STEPS rotations in every lane, then through the handoff and merge.
// One word is in flight at a time; req_stall is high from accept until the result
// is in the output register, which can hold a result while rsp_stall is high.
// Synchronous reset clears the integrators and sets the period to 655.
module imu_tilt_and_gyro_integrate_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_accel_x,
   input  logic signed [15:0]                  req_accel_y,
   input  logic signed [15:0]                  req_accel_z,
   input  logic signed [15:0]                  req_rate_x,
   input  logic signed [15:0]                  req_rate_y,
   input  logic signed [15:0]                  req_rate_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_tilt_x,
   output logic signed [15:0]                  rsp_tilt_y,
   output logic signed [15:0]                  rsp_tilt_z,
   output logic signed [imu_tg_pkg::TURN_W-1:0] rsp_turned_x,
   output logic signed [imu_tg_pkg::TURN_W-1:0] rsp_turned_y,
   output logic signed [imu_tg_pkg::TURN_W-1:0] rsp_turned_z,
   input  logic                                csr_wr_en,
   input  logic [15:0]                         csr_wr_data
);

   imu_tg_pkg::top_state_type state_ff, state_in;
   imu_tg_pkg::lane_res_type  lx, ly, lz;

   logic                 accept, can_load, load;
   logic [15:0]          period_ff;
   logic signed [15:0]   az_ff;
   logic                 prod_vld_ff;
   logic signed [imu_tg_pkg::PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [imu_tg_pkg::ACC_W-1:0]  acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [16:0]   period_s;
   logic signed [15:0]   tx, ty, tz;
   logic                 rsp_valid_ff;
   logic signed [15:0]   tilt_x_ff, tilt_y_ff, tilt_z_ff;
   logic signed [imu_tg_pkg::TURN_W-1:0] turned_x_ff, turned_y_ff, turned_z_ff;

   function automatic logic signed [imu_tg_pkg::ACC_W-1:0] sat_add(
      input logic signed [imu_tg_pkg::ACC_W-1:0]  acc,
      input logic signed [imu_tg_pkg::PROD_W-1:0] inc
   );
      logic signed [imu_tg_pkg::ACC_W:0] s;
      logic signed [imu_tg_pkg::ACC_W-1:0] r;
      s = (imu_tg_pkg::ACC_W+1)'(acc) + (imu_tg_pkg::ACC_W+1)'(inc);
      if (s[imu_tg_pkg::ACC_W] != s[imu_tg_pkg::ACC_W-1]) begin
         r = s[imu_tg_pkg::ACC_W] ? {1'b1, {(imu_tg_pkg::ACC_W-1){1'b0}}}
                                  : {1'b0, {(imu_tg_pkg::ACC_W-1){1'b1}}};
      end else begin
         r = s[imu_tg_pkg::ACC_W-1:0];
      end
      return r;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != imu_tg_pkg::S_IDLE);
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign load      = can_load && (((state_ff == imu_tg_pkg::S_BUSY) && lx.done) ||
                                    (state_ff == imu_tg_pkg::S_HOLD));

   imu_tg_lane u_lane_x (
      .clock (clock), .reset (reset), .start (accept),
      .a (req_accel_y), .b (req_accel_z), .num (req_accel_x), .z_mode (1'b0),
      .res (lx)
   );

   imu_tg_lane u_lane_y (
      .clock (clock), .reset (reset), .start (accept),
      .a (req_accel_x), .b (req_accel_z), .num (req_accel_y), .z_mode (1'b0),
      .res (ly)
   );

   imu_tg_lane u_lane_z (
      .clock (clock), .reset (reset), .start (accept),
      .a (req_accel_x), .b (req_accel_y), .num (req_accel_z), .z_mode (1'b1),
      .res (lz)
   );

   // Merge: zero root gives zero; for z, az of zero gives TILT_LIMIT, else az's sign.
   always_comb begin
      tx = lx.zero ? 16'sd0 : lx.angle;
      ty = ly.zero ? 16'sd0 : ly.angle;
      if (az_ff == 16'sd0) begin
         tz = lz.zero ? 16'sd0 : imu_tg_pkg::TILT_LIMIT;
      end else if (az_ff < 0) begin
         tz = -lz.angle;
      end else begin
         tz = lz.angle;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imu_tg_pkg::S_IDLE: if (accept) state_in = imu_tg_pkg::S_BUSY;
         imu_tg_pkg::S_BUSY: begin
            if (lx.done) state_in = can_load ? imu_tg_pkg::S_IDLE : imu_tg_pkg::S_HOLD;
         end
         imu_tg_pkg::S_HOLD: if (can_load) state_in = imu_tg_pkg::S_IDLE;
         default:            state_in = imu_tg_pkg::S_IDLE;
      endcase
   end

   assign period_s = $signed({1'b0, period_ff});

   always_ff @(posedge clock) begin
      if (accept) begin
         az_ff     <= req_accel_z;
         prod_x_ff <= req_rate_x * period_s;
         prod_y_ff <= req_rate_y * period_s;
         prod_z_ff <= req_rate_z * period_s;
      end
      if (load) begin
         tilt_x_ff   <= tx;
         tilt_y_ff   <= ty;
         tilt_z_ff   <= tz;
         turned_x_ff <= acc_x_ff[imu_tg_pkg::ACC_W-1:imu_tg_pkg::TURN_LSB];
         turned_y_ff <= acc_y_ff[imu_tg_pkg::ACC_W-1:imu_tg_pkg::TURN_LSB];
         turned_z_ff <= acc_z_ff[imu_tg_pkg::ACC_W-1:imu_tg_pkg::TURN_LSB];
      end
      if (reset) begin
         state_ff     <= imu_tg_pkg::S_IDLE;
         period_ff    <= imu_tg_pkg::PERIOD_RESET;
         prod_vld_ff  <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= accept;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (prod_vld_ff) begin
            acc_x_ff <= sat_add(acc_x_ff, prod_x_ff);
            acc_y_ff <= sat_add(acc_y_ff, prod_y_ff);
            acc_z_ff <= sat_add(acc_z_ff, prod_z_ff);
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tilt_x   = tilt_x_ff;
   assign rsp_tilt_y   = tilt_y_ff;
   assign rsp_tilt_z   = tilt_z_ff;
   assign rsp_turned_x = turned_x_ff;
   assign rsp_turned_y = turned_y_ff;
   assign rsp_turned_z = turned_z_ff;

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (lx.done == ly.done) && (ly.done == lz.done))
      else $error("tilt lanes finished out of step");

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input taken while a word is in flight");

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      lx.done |-> (state_ff == imu_tg_pkg::S_BUSY))
      else $error("lane finished with no word in flight");

   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (tilt_z_ff <= imu_tg_pkg::TILT_LIMIT) &&
                       (tilt_z_ff >= -imu_tg_pkg::TILT_LIMIT))
      else $error("tilt angle out of range");

endmodule

[tb/imu_tilt_gyro_checker.sv]
// Monitor, predictor and scoreboard for the IMU tilt and gyro unit.
module imu_tilt_gyro_checker
   import imu_tg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [15:0]       req_accel_x,
   input  logic signed [15:0]       req_accel_y,
   input  logic signed [15:0]       req_accel_z,
   input  logic signed [15:0]       req_rate_x,
   input  logic signed [15:0]       req_rate_y,
   input  logic signed [15:0]       req_rate_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [15:0]       rsp_tilt_x,
   input  logic signed [15:0]       rsp_tilt_y,
   input  logic signed [15:0]       rsp_tilt_z,
   input  logic signed [TURN_W-1:0] rsp_turned_x,
   input  logic signed [TURN_W-1:0] rsp_turned_y,
   input  logic signed [TURN_W-1:0] rsp_turned_z,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   output int                       failures,
   output int                       pending
);

   typedef struct packed {
      logic signed [15:0]       tilt_x;
      logic signed [15:0]       tilt_y;
      logic signed [15:0]       tilt_z;
      logic signed [TURN_W-1:0] turned_x;
      logic signed [TURN_W-1:0] turned_y;
      logic signed [TURN_W-1:0] turned_z;
   } angles_type;

   localparam longint signed SUM_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint signed SUM_MIN = -(64'sd1 <<< (ACC_W - 1));

   angles_type     angles_due[$];
   logic [15:0]    period;
   longint signed  sum_x, sum_y, sum_z;

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned scaled_mag(input longint signed a, input longint signed b);
      longint unsigned sq;
      sq = longint'(a * a) + longint'(b * b);
      return int_root(sq << (2 * SCALE_SHIFT));
   endfunction

   // Vectoring CORDIC; the angle accumulates in 2^-16 degree.
   function automatic logic signed [15:0] vector_angle(input longint signed x,
                                                       input longint signed y);
      longint signed z, dx, dy;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y < 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(atan_deg16(5'(i)));
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(atan_deg16(5'(i)));
         end
      end
      z = (z + 128) >>> 8;
      if (z > 23040) z = 23040;
      if (z < -23040) z = -23040;
      return 16'(z);
   endfunction

   function automatic logic signed [15:0] side_tilt(input longint signed num,
                                                    input longint signed a,
                                                    input longint signed b);
      longint unsigned den;
      den = scaled_mag(a, b);
      if (den == 0) return 16'sd0;
      return vector_angle(longint'(den), num <<< SCALE_SHIFT);
   endfunction

   function automatic longint signed clamp_sum(input longint signed acc, input longint signed inc);
      longint signed s;
      s = acc + inc;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      return s;
   endfunction

   function automatic angles_type predict_angles(input longint signed ax, input longint signed ay,
                                                 input longint signed az);
      angles_type r;
      longint unsigned horiz;
      longint signed mag_z;
      r = '0;
      r.tilt_x = side_tilt(ax, ay, az);
      r.tilt_y = side_tilt(ay, ax, az);
      horiz = scaled_mag(ax, ay);
      if (az == 0) begin
         r.tilt_z = (horiz == 0) ? 16'sd0 : TILT_LIMIT;
      end else begin
         mag_z = (az < 0) ? -az : az;
         r.tilt_z = vector_angle(mag_z <<< SCALE_SHIFT, longint'(horiz));
         if (az < 0) r.tilt_z = -r.tilt_z;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      angles_type want, got;
      longint signed per;
      if (reset) begin
         period <= PERIOD_RESET;
         sum_x = 0;
         sum_y = 0;
         sum_z = 0;
         angles_due.delete();
         failures <= 0;
      end else begin
         if (csr_wr_en) period <= csr_wr_data;
         if (req_valid && !req_stall) begin
            per = longint'(period);
            want = predict_angles(req_accel_x, req_accel_y, req_accel_z);
            sum_x = clamp_sum(sum_x, longint'(req_rate_x) * per);
            sum_y = clamp_sum(sum_y, longint'(req_rate_y) * per);
            sum_z = clamp_sum(sum_z, longint'(req_rate_z) * per);
            want.turned_x = TURN_W'(sum_x >>> TURN_LSB);
            want.turned_y = TURN_W'(sum_y >>> TURN_LSB);
            want.turned_z = TURN_W'(sum_z >>> TURN_LSB);
            angles_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_tilt_x, rsp_tilt_y, rsp_tilt_z,
                    rsp_turned_x, rsp_turned_y, rsp_turned_z};
            if (angles_due.size() == 0) begin
               failures <= failures + 1;
               if (failures < 10) $display("unexpected result word: %p", got);
            end else begin
               want = angles_due.pop_front();
               if (got !== want) begin
                  failures <= failures + 1;
                  if (failures < 10)
                     $display("result mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
      pending <= angles_due.size();
   end

endmodule

[tb/testbench.sv]
// Stimulus, clock, reset and verdict for the IMU tilt and gyro unit.
module testbench;
   import imu_tg_pkg::*;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic signed [15:0]       req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0]       req_rate_x = 0, req_rate_y = 0, req_rate_z = 0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic signed [15:0]       rsp_tilt_x, rsp_tilt_y, rsp_tilt_z;
   logic signed [TURN_W-1:0] rsp_turned_x, rsp_turned_y, rsp_turned_z;
   logic                     csr_wr_en = 0;
   logic [15:0]              csr_wr_data = 0;
   int                       failures, pending;
   bit                       no_gaps = 0;
   int                       stall_left = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   imu_tilt_and_gyro_integrate_unit dut (.*);
   imu_tilt_gyro_checker checker_i (.*);

   // Result side: after each accepted word, draw how long the next word is held
   // back once it shows up, and keep the stall up until then.
   always @(posedge clock) begin
      int h;
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         h = no_gaps ? 0 : $urandom_range(0, 18);
         stall_left <= h;
         rsp_stall <= (h > 0);
      end else if (rsp_valid && rsp_stall) begin
         if (stall_left <= 1) rsp_stall <= 0;
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_word(input logic [15:0] ax, ay, az, gx, gy, gz);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_rate_x <= gx;
      req_rate_y <= gy;
      req_rate_z <= gz;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h8000 + 16'($urandom_range(0, 3));
         1: return 16'h7FFF - 16'($urandom_range(0, 3));
         2: return 16'($signed($urandom_range(0, 16)) - 8);
         3: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_words(input int count);
      for (int i = 0; i < count; i++)
         send_word(pick_sample(), pick_sample(), pick_sample(),
                   16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Waits until every result is back and the unit has settled, then writes the period.
   task automatic set_period(input logic [15:0] value);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      // Extremes, zero denominators, az of zero and negative az.
      send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(0, 0, 0, 0, 0, 0);
      send_word(16'h1234, 0, 0, 1, 16'hFFFF, 0);
      send_word(0, 16'hF000, 0, 0, 0, 0);
      send_word(16'h7FFF, 16'h8000, 0, 16'h8000, 16'h7FFF, 1);
      send_word(0, 0, 16'h7FFF, 0, 0, 0);
      send_word(0, 0, 16'h8000, 0, 0, 0);
      send_word(100, 100, 16'hFF9C, 5, 5, 5);
      send_word(16'h8000, 16'h7FFF, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F);
      send_word(1, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF0F0, 16'h3333, 16'hCCCC);
      send_word(0, 0, 1, 0, 0, 0);
      send_word(1, 0, 16'hFFFF, 0, 0, 0);
      random_words(60);
      set_period(16'hFFFF);
      send_word(16'h7FFF, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
      random_words(80);
      set_period(16'd0);
      random_words(60);
      set_period(16'd1);
      no_gaps = 1;
      random_words(80);
      no_gaps = 0;
      set_period(16'($urandom));
      random_words(80);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
design/imu_tg_pkg.sv
design/imu_tg_isqrt.sv
design/imu_tg_cordic.sv
design/imu_tg_lane.sv
design/imu_tilt_and_gyro_integrate_unit.sv
tb/imu_tilt_gyro_checker.sv
tb/testbench.sv
